>>> sv/mdps_pkg.sv
// ----------------------------------------------------------------------------
// mdps_pkg
// Shared widths, types and limits for the maximum descent path sum block.
// ----------------------------------------------------------------------------
package mdps_pkg;

    // largest grid the line store holds
    localparam int MAX_GRID = 64;

    // field widths
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 22;
    localparam int COL_W  = 7;
    localparam int SIZE_W = 7;

    // internal widths that follow from the grid limit
    localparam int ADDR_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int N_W    = $clog2(MAX_GRID + 1);

    // stream byte widths
    localparam int S_DATA_W = ((VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SUM_W + COL_W + 7) / 8) * 8;

    // saturation limits of a path sum
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // grid position of one cell travelling to the compute stage
    typedef struct packed {
        logic              first_row;
        logic              first_col;
        logic              last_col;
        logic              last_row;
        logic [ADDR_W-1:0] col;
    } t_cell_ctl;

    // compute stage result
    typedef struct packed {
        logic                    emit;
        logic signed [SUM_W-1:0] row_sum;
        logic signed [SUM_W-1:0] best_sum;
        logic [COL_W-1:0]        best_column;
    } t_cell_res;

endpackage

>>> sv/max_descent_path_sum.sv
// ----------------------------------------------------------------------------
// max_descent_path_sum
// Streams an n-by-n grid in row-major order and reports the best top-to-bottom
// path sum and its bottom-row column after the last cell of each grid.
//
//   channel   dir  width  contents
//   s_axis    in   16     cell_value
//   m_axis    out  32     best_sum, best_column
//   cfg       in   7      grid_size
//
// One cell per cycle sustained unless the compute stage stalls. A cell is
// registered on its transfer while the right-hand neighbour is read from the
// line store; its sum is formed and written back when the compute stage
// commits, which also loads the result register for the last cell. Reset is
// synchronous and needs no clearing pass. Input ready drops only while a
// finished result waits and another result is due from the compute stage.
// ----------------------------------------------------------------------------
module max_descent_path_sum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cell stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [mdps_pkg::S_DATA_W-1:0]       i_s_tdata,  // [15:0] cell_value
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mdps_pkg::M_DATA_W-1:0]       o_m_tdata,  // [21:0] best_sum,
                                                            // [28:22] best_column
    // grid size register
    input  logic                                i_cfg_we,
    input  logic [mdps_pkg::SIZE_W-1:0]         i_cfg_wdata
);
    import mdps_pkg::*;

    // grid position and size
    logic [N_W-1:0]           r_grid_n;
    logic [ADDR_W-1:0]        r_col;
    logic [ADDR_W-1:0]        r_row;
    logic [N_W-1:0]           n_grid_n;

    // compute stage
    logic                     r_b_valid;
    t_cell_ctl                r_b_ctl;
    logic signed [VAL_W-1:0]  r_b_value;
    logic signed [SUM_W-1:0]  r_here_old;
    logic signed [SUM_W-1:0]  r_left_old;

    // output register
    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_out_sum;
    logic [COL_W-1:0]         r_out_col;

    logic                     s_accept;
    logic                     a_last_col;
    logic                     a_last_row;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [SUM_W-1:0]  rd_data;
    t_cell_ctl                a_ctl;
    t_cell_res                b_res;
    logic                     b_stall;
    logic                     b_commit;

    // position decode on the input side
    always_comb begin
        a_last_col = (N_W'(r_col) == (r_grid_n - N_W'(1)));
        a_last_row = (N_W'(r_row) == (r_grid_n - N_W'(1)));
        rd_addr    = a_last_col ? '0 : (r_col + ADDR_W'(1));
        a_ctl.first_row = (r_row == '0);
        a_ctl.first_col = (r_col == '0);
        a_ctl.last_col  = a_last_col;
        a_ctl.last_row  = a_last_row;
        a_ctl.col       = r_col;
    end

    // handshake
    assign b_stall    = r_b_valid && b_res.emit && r_out_valid && !i_m_tready;
    assign b_commit   = r_b_valid && !b_stall;
    assign o_s_tready = !b_stall;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // grid size clamp
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_grid_n = N_W'(1);
        end else if (32'(i_cfg_wdata) > MAX_GRID) begin
            n_grid_n = N_W'(MAX_GRID);
        end else begin
            n_grid_n = N_W'(i_cfg_wdata);
        end
    end

    // register write and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n <= N_W'(MAX_GRID);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            r_grid_n <= n_grid_n;
            r_col    <= '0;
            r_row    <= '0;
        end else if (s_accept) begin
            if (a_last_col) begin
                r_col <= '0;
                r_row <= a_last_row ? '0 : (r_row + ADDR_W'(1));
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    // compute stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (s_accept) begin
            r_b_valid <= 1'b1;
        end else if (b_commit) begin
            r_b_valid <= 1'b0;
        end
    end

    // compute stage payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_b_ctl   <= a_ctl;
            r_b_value <= i_s_tdata[VAL_W-1:0];
        end
    end

    // sliding window over the previous row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_here_old <= '0;
            r_left_old <= '0;
        end else if (b_commit) begin
            r_left_old <= r_here_old;
            r_here_old <= rd_data;
        end
    end

    mdps_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (b_commit),
        .i_wr_addr (r_b_ctl.col),
        .i_wr_data (b_res.row_sum)
    );

    mdps_cell_calc u_cell_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_commit(b_commit),
        .i_ctl   (r_b_ctl),
        .i_value (r_b_value),
        .i_here  (r_here_old),
        .i_left  (r_left_old),
        .i_right (rd_data),
        .o_res   (b_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_commit && b_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_commit && b_res.emit) begin
            r_out_sum <= b_res.best_sum;
            r_out_col <= b_res.best_column;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - SUM_W - COL_W){1'b0}}, r_out_col, r_out_sum};

    // checks
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_out_valid && r_b_valid))
        else $error("input stalled without a waiting result");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (N_W'(r_col) < r_grid_n) && (N_W'(r_row) < r_grid_n))
        else $error("grid position outside grid");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_b_valid && r_b_ctl.last_row && r_b_ctl.last_col))
        else $error("result without a final cell");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stall |=> (r_b_valid && $stable(r_b_ctl)))
        else $error("stalled cell lost");

endmodule

>>> sv/mdps_line_store.sv
// ----------------------------------------------------------------------------
// mdps_line_store
// Previous-row sum store: one write and one registered read per cycle, with
// write-to-read forwarding when both hit the same entry on the same edge.
// ----------------------------------------------------------------------------
module mdps_line_store (
    input  logic                                    i_clk,
    input  logic                                    i_rd_en,
    input  logic [mdps_pkg::ADDR_W-1:0]             i_rd_addr,
    output logic signed [mdps_pkg::SUM_W-1:0]       o_rd_data,
    input  logic                                    i_wr_en,
    input  logic [mdps_pkg::ADDR_W-1:0]             i_wr_addr,
    input  logic signed [mdps_pkg::SUM_W-1:0]       i_wr_data
);
    import mdps_pkg::*;

    logic signed [SUM_W-1:0] r_mem [MAX_GRID];
    logic signed [SUM_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, newest data wins on an address clash
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/mdps_cell_calc.sv
// ----------------------------------------------------------------------------
// mdps_cell_calc
// Cell sum from the largest of up to three upper neighbours plus the running
// best of the bottom row.
// ----------------------------------------------------------------------------
module mdps_cell_calc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_commit,
    input  mdps_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [mdps_pkg::VAL_W-1:0]   i_value,
    input  logic signed [mdps_pkg::SUM_W-1:0]   i_here,
    input  logic signed [mdps_pkg::SUM_W-1:0]   i_left,
    input  logic signed [mdps_pkg::SUM_W-1:0]   i_right,
    output mdps_pkg::t_cell_res                 o_res
);
    import mdps_pkg::*;

    logic signed [SUM_W-1:0]  r_best;
    logic [ADDR_W-1:0]        r_best_col;

    logic signed [SUM_W-1:0]  best_up;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  cell_sum;
    logic                     take;
    logic signed [SUM_W-1:0]  best_sum;
    logic [ADDR_W-1:0]        best_col;

    // largest neighbour above, then add and saturate
    always_comb begin
        best_up = i_here;
        if (!i_ctl.first_col && (i_left > best_up)) begin
            best_up = i_left;
        end
        if (!i_ctl.last_col && (i_right > best_up)) begin
            best_up = i_right;
        end
        sum_wide = {best_up[SUM_W-1], best_up}
                 + {{(SUM_W + 1 - VAL_W){i_value[VAL_W-1]}}, i_value};
        if (i_ctl.first_row) begin
            cell_sum = {{(SUM_W - VAL_W){i_value[VAL_W-1]}}, i_value};
        end else if (sum_wide > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
            cell_sum = SUM_MAX;
        end else if (sum_wide < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
            cell_sum = SUM_MIN;
        end else begin
            cell_sum = sum_wide[SUM_W-1:0];
        end
    end

    // first maximum of the bottom row wins
    always_comb begin
        take     = i_ctl.first_col || (cell_sum > r_best);
        best_sum = take ? cell_sum : r_best;
        best_col = take ? i_ctl.col : r_best_col;
    end

    // running best over the bottom row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= '0;
            r_best_col <= '0;
        end else if (i_commit && i_ctl.last_row) begin
            r_best     <= best_sum;
            r_best_col <= best_col;
        end
    end

    assign o_res.emit        = i_ctl.last_row && i_ctl.last_col;
    assign o_res.row_sum     = cell_sum;
    assign o_res.best_sum    = best_sum;
    assign o_res.best_column = COL_W'(best_col) + COL_W'(1);

endmodule
